// ===== design/acs_pkg.sv =====
`timescale 1ns / 1ps

package acs_pkg;

  localparam int unsigned ACS_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_END  = 8'h00;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OPEN  = 2'd1;
  localparam logic [1:0] ERR_CLOSE = 2'd2;

  localparam logic [3:0] ST_NORMAL     = 4'd0;
  localparam logic [3:0] ST_DASH       = 4'd1;
  localparam logic [3:0] ST_SEMI       = 4'd2;
  localparam logic [3:0] ST_LINE       = 4'd3;
  localparam logic [3:0] ST_LINE_CR    = 4'd4;
  localparam logic [3:0] ST_BLOCK      = 4'd5;
  localparam logic [3:0] ST_BLOCK_DASH = 4'd6;
  localparam logic [3:0] ST_CLOSED     = 4'd7;
  localparam logic [3:0] ST_CLOSED_CR  = 4'd8;
  localparam logic [3:0] ST_ERR_OPEN   = 4'd9;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t res_byte(input logic [7:0] b);
    res_t r;
    r.data   = b;
    r.is_end = 1'b0;
    r.err    = ERR_NONE;
    return r;
  endfunction

  function automatic res_t res_end(input logic [1:0] e);
    res_t r;
    r.data   = CH_END;
    r.is_end = 1'b1;
    r.err    = e;
    return r;
  endfunction

endpackage

// ===== design/asm_comment_stripper.sv =====
`timescale 1ns / 1ps

// Assembler comment stripper.
// Input channel: in_valid / in_stall carry one source byte per transfer on
// in_byte; byte 0 ends the text. Output channel: out_valid / out_stall carry
// one kept byte per transfer, or the end result (out_is_end high, out_byte 0,
// out_error_code 1 for a missing block opener, 2 for a missing closer).
// A source byte gives none, one or two results.
// A taken byte waits in the holding register; its results are written from
// there into the output queue, and out_valid is registered from the queue's
// count, so a result reaches the output only after both registers.
// Throughput: one byte per cycle while each byte gives at most one result;
// a byte that gives two results takes two output transfers. The holding
// register moves on only while the output queue has room for two results.
// Reset (rst_n low, synchronous) empties the queue and the holding register
// and returns the parser to plain text.
// When the receiver stalls, the queue fills and in_stall rises once fewer
// than two entries are free while a byte is held; no result is lost or reordered.
module asm_comment_stripper #(
  parameter int unsigned FIFO_DEPTH = acs_pkg::ACS_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_end,
  output logic [1:0] out_error_code
);
  import acs_pkg::*;

  logic       hold_vld_r;
  logic [7:0] hold_byte_r;
  logic       room2;
  logic       adv;
  push_t      push;

  assign adv      = hold_vld_r && room2;
  assign in_stall = hold_vld_r && !room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (!in_stall) begin
      hold_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte_r <= in_byte;
    end
  end

  acs_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .byte_i (hold_byte_r),
    .push   (push)
  );

  acs_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .room2          (room2),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_end     (out_is_end),
    .out_error_code (out_error_code)
  );

endmodule

// ===== design/acs_parser.sv =====
`timescale 1ns / 1ps

module acs_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [7:0]     byte_i,
  output acs_pkg::push_t push
);
  import acs_pkg::*;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // plain-text handling of the current byte
  logic [3:0] n_st;
  logic       n_emit;
  res_t       n_res;

  push_t      p;

  always_comb begin
    n_st   = ST_NORMAL;
    n_emit = 1'b0;
    n_res  = res_byte(byte_i);
    priority if (byte_i == CH_END) begin
      n_emit = 1'b1;
      n_res  = res_end(ERR_NONE);
    end else if (byte_i == CH_DASH) begin
      n_st = ST_DASH;
    end else if (byte_i == CH_SEMI) begin
      n_st = ST_SEMI;
    end else begin
      n_emit = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    p.cnt     = 2'd0;
    p.r0      = n_res;
    p.r1      = n_res;
    unique case (state_r)
      ST_DASH: begin
        if (byte_i == CH_SEMI) begin
          state_nxt = ST_ERR_OPEN;
        end else begin
          p.r0      = res_byte(CH_DASH);
          p.cnt     = n_emit ? 2'd2 : 2'd1;
          state_nxt = n_st;
        end
      end
      ST_SEMI: begin
        priority if (byte_i == CH_END) begin
          p.cnt = 2'd1; p.r0 = res_end(ERR_NONE); state_nxt = ST_NORMAL;
        end else if (byte_i == CH_DASH) begin
          state_nxt = ST_BLOCK;
        end else if (byte_i == CH_CR) begin
          p.cnt = 2'd1; p.r0 = res_byte(CH_CR); state_nxt = ST_LINE_CR;
        end else begin
          state_nxt = ST_LINE;
        end
      end
      ST_LINE: begin
        priority if (byte_i == CH_END) begin
          p.cnt = 2'd1; p.r0 = res_end(ERR_NONE); state_nxt = ST_NORMAL;
        end else if (byte_i == CH_CR) begin
          p.cnt = 2'd1; p.r0 = res_byte(CH_CR); state_nxt = ST_LINE_CR;
        end else begin
          state_nxt = ST_LINE;
        end
      end
      ST_LINE_CR: begin
        priority if (byte_i == CH_END) begin
          p.cnt = 2'd1; p.r0 = res_end(ERR_NONE); state_nxt = ST_NORMAL;
        end else if (byte_i == CH_LF) begin
          p.cnt = 2'd1; p.r0 = res_byte(CH_LF); state_nxt = ST_NORMAL;
        end else begin
          state_nxt = ST_LINE;
        end
      end
      ST_BLOCK: begin
        priority if (byte_i == CH_END) begin
          p.cnt = 2'd1; p.r0 = res_end(ERR_CLOSE); state_nxt = ST_NORMAL;
        end else if (byte_i == CH_DASH) begin
          state_nxt = ST_BLOCK_DASH;
        end else begin
          state_nxt = ST_BLOCK;
        end
      end
      ST_BLOCK_DASH: begin
        priority if (byte_i == CH_END) begin
          p.cnt = 2'd1; p.r0 = res_end(ERR_CLOSE); state_nxt = ST_NORMAL;
        end else if (byte_i == CH_SEMI) begin
          state_nxt = ST_CLOSED;
        end else begin
          state_nxt = ST_BLOCK;
        end
      end
      ST_CLOSED: begin
        if (byte_i == CH_CR) begin
          state_nxt = ST_CLOSED_CR;
        end else begin
          p.cnt     = n_emit ? 2'd1 : 2'd0;
          state_nxt = n_st;
        end
      end
      ST_CLOSED_CR: begin
        if (byte_i == CH_LF) begin
          state_nxt = ST_NORMAL;
        end else begin
          p.r0      = res_byte(CH_CR);
          p.cnt     = n_emit ? 2'd2 : 2'd1;
          state_nxt = n_st;
        end
      end
      ST_ERR_OPEN: begin
        if (byte_i == CH_END) begin
          p.cnt = 2'd1; p.r0 = res_end(ERR_OPEN); state_nxt = ST_NORMAL;
        end
      end
      default: begin
        p.cnt     = n_emit ? 2'd1 : 2'd0;
        state_nxt = n_st;
      end
    endcase
  end

  always_comb begin
    push = p;
    if (!en) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
    end else if (en) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/acs_out_fifo.sv =====
`timescale 1ns / 1ps

module acs_out_fifo #(
  parameter int unsigned DEPTH = acs_pkg::ACS_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  acs_pkg::push_t push,
  output logic           room2,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_is_end,
  output logic [1:0]     out_error_code
);
  import acs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
  endfunction

  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;

  assign out_byte       = mem[rd_ptr_r].data;
  assign out_is_end     = mem[rd_ptr_r].is_end;
  assign out_error_code = mem[rd_ptr_r].err;

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    unique case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("output queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room2)
    else $error("push without room in output queue");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && push.cnt != 2'd0) |=> out_valid)
    else $error("pushed result not presented");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import acs_pkg::*;

  localparam int N_ITEMS    = 1350;
  localparam int LONG_AT    = 500;
  localparam int QUIET_AT   = 1200;
  localparam int LONG_HOLD  = 150;
  localparam int DRAIN_CYC  = 8;

  class strip_scoreboard;
    logic [3:0] parse_st;
    res_t       expected_out[$];
    int         errors;
    int         checked;
    int         ends_by_code[3];

    function new();
      parse_st = ST_NORMAL;
      errors   = 0;
      checked  = 0;
      foreach (ends_by_code[i]) ends_by_code[i] = 0;
    endfunction

    function void keep(input logic [7:0] b);
      res_t r;
      r.data   = b;
      r.is_end = 1'b0;
      r.err    = ERR_NONE;
      expected_out.push_back(r);
    endfunction

    function void end_text(input logic [1:0] e);
      res_t r;
      r.data   = CH_END;
      r.is_end = 1'b1;
      r.err    = e;
      expected_out.push_back(r);
      parse_st = ST_NORMAL;
    endfunction

    function void plain_text_byte(input logic [7:0] b);
      if (b == CH_END) end_text(ERR_NONE);
      else if (b == CH_DASH) parse_st = ST_DASH;
      else if (b == CH_SEMI) parse_st = ST_SEMI;
      else begin
        parse_st = ST_NORMAL;
        keep(b);
      end
    endfunction

    function void note_source_byte(input logic [7:0] b);
      case (parse_st)
        ST_DASH: begin
          if (b == CH_SEMI) parse_st = ST_ERR_OPEN;
          else begin
            keep(CH_DASH);
            plain_text_byte(b);
          end
        end
        ST_SEMI: begin
          if (b == CH_END) end_text(ERR_NONE);
          else if (b == CH_DASH) parse_st = ST_BLOCK;
          else if (b == CH_CR) begin
            parse_st = ST_LINE_CR;
            keep(CH_CR);
          end else parse_st = ST_LINE;
        end
        ST_LINE: begin
          if (b == CH_END) end_text(ERR_NONE);
          else if (b == CH_CR) begin
            parse_st = ST_LINE_CR;
            keep(CH_CR);
          end
        end
        ST_LINE_CR: begin
          if (b == CH_END) end_text(ERR_NONE);
          else if (b == CH_LF) begin
            parse_st = ST_NORMAL;
            keep(CH_LF);
          end else parse_st = ST_LINE;
        end
        ST_BLOCK: begin
          if (b == CH_END) end_text(ERR_CLOSE);
          else if (b == CH_DASH) parse_st = ST_BLOCK_DASH;
        end
        ST_BLOCK_DASH: begin
          if (b == CH_END) end_text(ERR_CLOSE);
          else parse_st = (b == CH_SEMI) ? ST_CLOSED : ST_BLOCK;
        end
        ST_CLOSED: begin
          if (b == CH_CR) parse_st = ST_CLOSED_CR;
          else plain_text_byte(b);
        end
        ST_CLOSED_CR: begin
          if (b == CH_LF) parse_st = ST_NORMAL;
          else begin
            keep(CH_CR);
            plain_text_byte(b);
          end
        end
        ST_ERR_OPEN: begin
          if (b == CH_END) end_text(ERR_OPEN);
        end
        default: plain_text_byte(b);
      endcase
    endfunction

    function void check_result(input logic [7:0] d, input logic e, input logic [1:0] c);
      res_t want;
      checked++;
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte=%h end=%b err=%0d", $time, d, e, c);
        return;
      end
      want = expected_out.pop_front();
      if (want.is_end) ends_by_code[want.err]++;
      if (d !== want.data) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want.data, d);
      end
      if (e !== want.is_end) begin
        errors++;
        $display("%0t: out_is_end expected %b actual %b", $time, want.is_end, e);
      end
      if (c !== want.err) begin
        errors++;
        $display("%0t: out_error_code expected %0d actual %0d", $time, want.err, c);
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_end;
  logic [1:0] out_error_code;

  logic quiet = 1'b0;
  logic long_hold_go = 1'b0;

  strip_scoreboard sb = new();
  int items_sent = 0;
  int texts_sent = 0;

  logic [7:0] directed_src [0:30] = '{
    8'hFF, 8'h01, CH_DASH, CH_DASH, 8'h61,
    CH_SEMI, CH_CR, CH_LF,
    CH_SEMI, 8'h63, CH_CR, 8'h71, CH_CR, CH_LF,
    CH_SEMI, CH_DASH, CH_DASH, 8'h78, CH_DASH, CH_SEMI, CH_CR, 8'h51,
    CH_DASH, CH_SEMI, 8'h6A, CH_END,
    CH_SEMI, CH_DASH, 8'h75, CH_DASH, CH_END
  };

  asm_comment_stripper dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_end     (out_is_end),
    .out_error_code (out_error_code)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == a || v == c);
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_source_byte(b);
    items_sent++;
    if (b == CH_END) texts_sent++;
    if (items_sent == LONG_AT) long_hold_go <= 1'b1;
    if (items_sent == QUIET_AT) quiet <= 1'b1;
  endtask

  // result transfers
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result(out_byte, out_is_end, out_error_code);
  end

  // receiver hold-off
  initial begin
    bit hold_done;
    int r;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (quiet || rst_n !== 1'b1) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 15);
        if (r < 4) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          out_stall <= 1'b0;
        end else if (r == 4) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [7:0] text[$];
    int kind;
    int r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_src[i]) send_byte(directed_src[i]);

    while (items_sent < N_ITEMS) begin
      text.delete();
      repeat ($urandom_range(1, 6)) begin
        kind = $urandom_range(0, 19);
        if (kind < 6) begin
          repeat ($urandom_range(1, 6)) text.push_back(rand_byte_except(CH_SEMI, CH_DASH));
        end else if (kind < 10) begin
          // line comment
          text.push_back(CH_SEMI);
          repeat ($urandom_range(0, 6)) text.push_back(rand_byte_except(CH_CR, CH_CR));
          r = $urandom_range(0, 5);
          if (r < 4) begin
            text.push_back(CH_CR);
            text.push_back(CH_LF);
          end else if (r == 4) begin
            text.push_back(CH_CR);
            text.push_back(rand_byte_except(CH_LF, CH_LF));
          end
        end else if (kind < 15) begin
          // block comment, sometimes left open
          text.push_back(CH_SEMI);
          text.push_back(CH_DASH);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
              text.push_back(CH_DASH);
              text.push_back(rand_byte_except(CH_SEMI, CH_SEMI));
            end else begin
              text.push_back(rand_byte_except(CH_DASH, CH_DASH));
            end
          end
          if ($urandom_range(0, 7) != 0) begin
            text.push_back(CH_DASH);
            text.push_back(CH_SEMI);
            r = $urandom_range(0, 3);
            if (r == 0) begin
              text.push_back(CH_CR);
              text.push_back(CH_LF);
            end else if (r == 1) begin
              text.push_back(CH_CR);
            end
          end
        end else if (kind < 17) begin
          text.push_back(CH_DASH);
          if ($urandom_range(0, 1) == 1) text.push_back(CH_DASH);
        end else if (kind < 19) begin
          repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(1, 255)));
        end else begin
          text.push_back(CH_DASH);
          text.push_back(CH_SEMI);
          text.push_back(8'($urandom_range(1, 255)));
        end
      end
      text.push_back(CH_END);
      foreach (text[i]) send_byte(text[i]);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d source bytes in %0d texts, %0d results checked, one %0d-cycle hold-off.",
             items_sent, texts_sent, sb.checked, LONG_HOLD);
    $display("End results: %0d clean, %0d missing opener, %0d missing closer.",
             sb.ends_by_code[ERR_NONE], sb.ends_by_code[ERR_OPEN], sb.ends_by_code[ERR_CLOSE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/acs_pkg.sv
design/acs_parser.sv
design/acs_out_fifo.sv
design/asm_comment_stripper.sv
sim/tb.sv
